[hw/rtl/bssc_pkg.sv]
// Package for the six-step back-EMF commutator: word types, codes and lookup tables.
`default_nettype none

package bssc_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DIRECTION    = 1'b0;
    localparam logic CFG_DELAY_PRESET = 1'b1;

    localparam int CFG_DATA_W = 6;

    localparam logic [7:0] INTERVAL_CLAMP  = 8'd40;
    localparam logic [7:0] START_INTERVAL  = 8'd50;
    localparam logic [7:0] INTERVAL_MAX    = 8'd255;
    localparam logic [5:0] LEVEL_MAX       = 6'd63;
    localparam logic [5:0] DELAY_PRESET_RST = 6'd8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] bemf_bits;
        logic [2:0] start_position;
    } in_word_t;

    typedef struct packed {
        logic [2:0] bridge_step;
        logic       commutated;
        logic [2:0] sector;
        logic [5:0] delay_level;
        logic       start_fault;
    } out_word_t;

    function automatic logic [2:0] pos_to_sector(input logic [2:0] pos);
        logic [2:0] r;
        case (pos)
            3'd1: r = 3'd1;
            3'd2: r = 3'd2;
            3'd3: r = 3'd4;
            3'd4: r = 3'd5;
            3'd5: r = 3'd6;
            3'd6: r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] start_key(input logic dir, input logic [2:0] pos);
        logic [2:0] r;
        case (pos)
            3'd1: r = dir ? 3'd6 : 3'd1;
            3'd2: r = 3'd3;
            3'd3: r = 3'd5;
            3'd4: r = 3'd5;
            3'd5: r = 3'd6;
            3'd6: r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] key_to_index(input logic [2:0] key);
        logic [2:0] r;
        case (key)
            3'd1: r = 3'd1;
            3'd2: r = 3'd5;
            3'd3: r = 3'd4;
            3'd4: r = 3'd6;
            3'd5: r = 3'd2;
            3'd6: r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] fwd_step(input logic [2:0] idx);
        logic [2:0] r;
        case (idx)
            3'd1: r = 3'd1;
            3'd2: r = 3'd6;
            3'd3: r = 3'd5;
            3'd4: r = 3'd2;
            3'd5: r = 3'd4;
            3'd6: r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] rev_step(input logic [2:0] idx);
        logic [2:0] r;
        case (idx)
            3'd1: r = 3'd5;
            3'd2: r = 3'd4;
            3'd3: r = 3'd1;
            3'd4: r = 3'd3;
            3'd5: r = 3'd6;
            3'd6: r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] bridge_for(input logic dir, input logic [2:0] key);
        logic [2:0] idx;
        idx = key_to_index(key);
        return dir ? rev_step(idx) : fwd_step(idx);
    endfunction

    // Comparator phase watched in each sector
    function automatic logic [2:0] edge_mask(input logic dir, input logic [2:0] sec);
        logic [2:0] r;
        case (sec)
            3'd1: r = dir ? 3'h4 : 3'h2;
            3'd2: r = dir ? 3'h2 : 3'h4;
            3'd3: r = 3'h1;
            3'd4: r = dir ? 3'h4 : 3'h2;
            3'd5: r = dir ? 3'h2 : 3'h4;
            3'd6: r = 3'h1;
            default: r = 3'h0;
        endcase
        return r;
    endfunction

    // Level the watched phase must show for the edge to count
    function automatic logic [2:0] edge_want(input logic dir, input logic [2:0] sec);
        logic [2:0] r;
        case (sec)
            3'd2: r = dir ? 3'h2 : 3'h4;
            3'd4: r = dir ? 3'h4 : 3'h2;
            3'd6: r = 3'h1;
            default: r = 3'h0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bssc_core.sv]
// Commutation state, configuration registers and per-word next-state logic.
`default_nettype none

module bssc_core #(
    parameter logic [7:0] INTERVAL_CLAMP = bssc_pkg::INTERVAL_CLAMP
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_addr,
    input  wire logic [bssc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              item_valid,
    input  wire bssc_pkg::in_word_t                item,
    output bssc_pkg::out_word_t                    result
);
    import bssc_pkg::*;

    logic       direction_reg;
    logic [5:0] delay_preset_reg;

    logic [2:0] sector_reg,   sector_next;
    logic [7:0] interval_reg, interval_next;
    logic [5:0] tracked_reg,  tracked_next;
    logic [2:0] step_reg,     step_next;
    logic [5:0] level_reg,    level_next;

    logic       commutated;
    logic       fault;
    logic [2:0] start_sector;
    logic [7:0] clamped;
    logic [6:0] half;
    logic [2:0] mask;
    logic [2:0] want;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg    <= 1'b0;
            delay_preset_reg <= DELAY_PRESET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DIRECTION:    direction_reg    <= cfg_wdata[0];
                CFG_DELAY_PRESET: delay_preset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        sector_next   = sector_reg;
        interval_next = interval_reg;
        tracked_next  = tracked_reg;
        step_next     = step_reg;
        level_next    = level_reg;
        commutated    = 1'b0;
        fault         = 1'b0;

        start_sector = pos_to_sector(item.start_position);
        clamped      = (interval_reg > INTERVAL_CLAMP) ? INTERVAL_CLAMP : interval_reg;
        half         = clamped[7:1];
        mask         = edge_mask(direction_reg, sector_reg);
        want         = edge_want(direction_reg, sector_reg);

        case (item.req_type)
            REQ_START: begin
                if (start_sector != 3'd0) begin
                    sector_next   = start_sector;
                    interval_next = START_INTERVAL;
                    tracked_next  = delay_preset_reg;
                    level_next    = delay_preset_reg;
                    step_next     = bridge_for(direction_reg,
                                        start_key(direction_reg, item.start_position));
                    commutated    = 1'b1;
                end else begin
                    sector_next = 3'd0;
                    step_next   = 3'd0;
                    fault       = 1'b1;
                end
            end
            REQ_TICK: begin
                if (interval_reg != INTERVAL_MAX) begin
                    interval_next = interval_reg + 8'd1;
                end
            end
            REQ_SAMPLE: begin
                if (sector_reg != 3'd0 && sector_reg != 3'd7
                        && (item.bemf_bits & mask) == want) begin
                    sector_next   = (sector_reg == 3'd6) ? 3'd1 : sector_reg + 3'd1;
                    step_next     = bridge_for(direction_reg, sector_reg);
                    interval_next = 8'd0;
                    commutated    = 1'b1;
                    // one step toward half the clamped interval
                    if ({1'b0, tracked_reg} < half && tracked_reg < LEVEL_MAX) begin
                        tracked_next = tracked_reg + 6'd1;
                    end else if ({1'b0, tracked_reg} > half && tracked_reg > 6'd1) begin
                        tracked_next = tracked_reg - 6'd1;
                    end
                    level_next = tracked_next;
                end
            end
            default: ;
        endcase

        result.bridge_step = step_next;
        result.commutated  = commutated;
        result.sector      = sector_next;
        result.delay_level = level_next;
        result.start_fault = fault;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg   <= 3'd0;
            interval_reg <= 8'd0;
            tracked_reg  <= 6'd0;
            step_reg     <= 3'd0;
            level_reg    <= 6'd0;
        end else if (item_valid) begin
            sector_reg   <= sector_next;
            interval_reg <= interval_next;
            tracked_reg  <= tracked_next;
            step_reg     <= step_next;
            level_reg    <= level_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bemf_six_step_commutator_unit.sv]
// Top level of the sensorless six-step back-EMF commutator with output skid buffer.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_data  (req_type, bemf_bits, start_position)
//  m_        out        m_valid/m_ready    m_data  (bridge_step, commutated, sector,
//                                                   delay_level, start_fault)
//  cfg_      in         cfg_wr_en          cfg_addr, cfg_wdata (no wait, no read-back)
//
// One word per cycle while s_ready is high: each word is decoded against the state
// registers when accepted; its result lands on that edge in the output or skid register.
// A two-entry output buffer (output register plus skid register) lets input keep
// flowing while a result waits; s_ready drops only when both entries are full.
// Reset (aresetn low at a clock edge) stops the motor state and empties the buffer.
`default_nettype none

module bemf_six_step_commutator_unit #(
    parameter logic [7:0] INTERVAL_CLAMP = bssc_pkg::INTERVAL_CLAMP
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_addr,
    input  wire logic [bssc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire bssc_pkg::in_word_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output bssc_pkg::out_word_t                    m_data
);
    import bssc_pkg::*;

    logic      accept;
    logic      pop;
    out_word_t core_result;

    logic      main_valid_reg;
    logic      skid_valid_reg;
    out_word_t main_reg;
    out_word_t skid_reg;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;
    assign pop     = main_valid_reg && m_ready;

    bssc_core #(
        .INTERVAL_CLAMP (INTERVAL_CLAMP)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .item_valid (accept),
        .item       (s_data),
        .result     (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (!main_valid_reg || pop) begin
                    // skid is empty whenever a word is taken
                    main_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!main_valid_reg || pop) begin
                main_reg <= core_result;
            end else begin
                skid_reg <= core_result;
            end
        end else if (pop && skid_valid_reg) begin
            main_reg <= skid_reg;
        end
    end

endmodule

`default_nettype wire
